// ===== hw/rtl/rt2d_pkg.sv =====
// Shared constants, register indexes and the arctangent table for the planar
// rigid transform block. No dependencies; imported by every module of the block.
package rt2d_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TRIG_WIDTH      = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int STEP_WIDTH      = 4;
  localparam int PHASE_WIDTH     = 36;
  localparam int ROT_WIDTH       = 34;
  localparam int CFG_INDEX_WIDTH = 4;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE       = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_X     = 4'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Y     = 4'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_USE_INVERSE = 4'd3;

  localparam logic signed [PHASE_WIDTH-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [PHASE_WIDTH-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [ROT_WIDTH-1:0]   CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [TRIG_WIDTH-1:0]  TRIG_ONE    = 16'sd16384;

  function automatic logic signed [PHASE_WIDTH-1:0] atan_q30(
    input logic [STEP_WIDTH-1:0] step
  );
    logic signed [PHASE_WIDTH-1:0] value;
    case (step)
      4'd0:    value = 36'sd843314856;
      4'd1:    value = 36'sd497837829;
      4'd2:    value = 36'sd263043836;
      4'd3:    value = 36'sd133525158;
      4'd4:    value = 36'sd67021686;
      4'd5:    value = 36'sd33543515;
      4'd6:    value = 36'sd16775850;
      4'd7:    value = 36'sd8388437;
      4'd8:    value = 36'sd4194282;
      4'd9:    value = 36'sd2097149;
      4'd10:   value = 36'sd1048575;
      4'd11:   value = 36'sd524287;
      4'd12:   value = 36'sd262143;
      4'd13:   value = 36'sd131071;
      4'd14:   value = 36'sd65535;
      4'd15:   value = 36'sd32767;
      default: value = 36'sd0;
    endcase
    return value;
  endfunction

endpackage

// ===== hw/rtl/rt2d_cordic.sv =====
// Iterative CORDIC that turns the configured angle into Q1.14 cosine and sine,
// one rotation step per cycle. Depends on rt2d_pkg.
module rt2d_cordic import rt2d_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output logic                          busy,
  output logic signed [TRIG_WIDTH-1:0]  cos_value,
  output logic signed [TRIG_WIDTH-1:0]  sin_value
);

  localparam int ANGLE_SHIFT = 33 - ANGLE_WIDTH;
  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_RUN  = 1'b1;
  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(CORDIC_STEPS - 1);

  logic                          state;
  logic [STEP_WIDTH-1:0]         step;
  logic signed [PHASE_WIDTH-1:0] phase;
  logic signed [ROT_WIDTH-1:0]   rot_x;
  logic signed [ROT_WIDTH-1:0]   rot_y;
  logic                          flip;

  logic signed [PHASE_WIDTH-1:0] phase_wide;
  logic signed [PHASE_WIDTH-1:0] phase_start;
  logic signed [PHASE_WIDTH-1:0] phase_fold;
  logic                          flip_start;
  logic signed [ROT_WIDTH-1:0]   dx;
  logic signed [ROT_WIDTH-1:0]   dy;
  logic signed [PHASE_WIDTH-1:0] phase_next;
  logic signed [ROT_WIDTH-1:0]   rot_x_next;
  logic signed [ROT_WIDTH-1:0]   rot_y_next;

  function automatic logic signed [TRIG_WIDTH-1:0] to_unit(
    input logic signed [ROT_WIDTH-1:0] v,
    input logic                        neg
  );
    logic signed [ROT_WIDTH-1:0]  r;
    logic signed [TRIG_WIDTH-1:0] c;
    r = (v + ROT_WIDTH'(32768)) >>> 16;
    if (r > ROT_WIDTH'(TRIG_ONE)) begin
      c = TRIG_ONE;
    end else if (r < -ROT_WIDTH'(TRIG_ONE)) begin
      c = -TRIG_ONE;
    end else begin
      c = r[TRIG_WIDTH-1:0];
    end
    return neg ? -c : c;
  endfunction

  always_comb begin
    phase_wide  = {{(PHASE_WIDTH - ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle};
    phase_start = phase_wide <<< ANGLE_SHIFT;
    if (phase_start > Q30_HALF_PI) begin
      phase_fold = phase_start - Q30_PI;
      flip_start = 1'b1;
    end else if (phase_start < -Q30_HALF_PI) begin
      phase_fold = phase_start + Q30_PI;
      flip_start = 1'b1;
    end else begin
      phase_fold = phase_start;
      flip_start = 1'b0;
    end
  end

  always_comb begin
    dx = rot_y >>> step;
    dy = rot_x >>> step;
    if (!phase[PHASE_WIDTH-1]) begin
      rot_x_next = rot_x - dx;
      rot_y_next = rot_y + dy;
      phase_next = phase - atan_q30(step);
    end else begin
      rot_x_next = rot_x + dx;
      rot_y_next = rot_y - dy;
      phase_next = phase + atan_q30(step);
    end
  end

  assign busy = (state == STATE_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_IDLE;
      step      <= '0;
      cos_value <= TRIG_ONE;
      sin_value <= '0;
    end else begin
      case (state)
        STATE_IDLE: begin
          if (start) begin
            state <= STATE_RUN;
            step  <= '0;
          end
        end
        STATE_RUN: begin
          step <= step + STEP_WIDTH'(1);
          if (step == LAST_STEP) begin
            state     <= STATE_IDLE;
            cos_value <= to_unit(rot_x_next, flip);
            sin_value <= to_unit(rot_y_next, flip);
          end
        end
        default: begin
          state <= STATE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == STATE_IDLE) begin
      phase <= phase_fold;
      flip  <= flip_start;
      rot_x <= CORDIC_GAIN;
      rot_y <= '0;
    end else begin
      phase <= phase_next;
      rot_x <= rot_x_next;
      rot_y <= rot_y_next;
    end
  end

endmodule

// ===== hw/rtl/rt2d_datapath.sv =====
// Four-stage point pipeline: input register, products, rounded sums, and the
// saturating result register. Depends on rt2d_pkg.
module rt2d_datapath import rt2d_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [TRIG_WIDTH-1:0]  cos_value,
  input  logic signed [TRIG_WIDTH-1:0]  sin_value,
  input  logic signed [COORD_WIDTH-1:0] shift_x,
  input  logic signed [COORD_WIDTH-1:0] shift_y,
  input  logic                          use_inverse,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] moved_x,
  output logic signed [COORD_WIDTH-1:0] moved_y,
  output logic                          clipped
);

  localparam int PW = COORD_WIDTH + TRIG_WIDTH;
  localparam int SW = PW + 1;
  localparam int RW = SW - 14;
  localparam int TW = RW + 1;
  localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                          v0, v1, v2;
  logic                          rdy0, rdy1, rdy2, rdy3;
  logic signed [COORD_WIDTH-1:0] px0, py0;
  logic signed [PW-1:0]          cpx, spy, spx, cpy, ctx, sty, stx, cty;
  logic signed [RW-1:0]          rx2, ry2, ox2, oy2;

  logic signed [SW-1:0] sum_x, sum_y, off_sum_x, off_sum_y;
  logic signed [RW-1:0] rnd_x, rnd_y, off_x, off_y;
  logic signed [TW-1:0] total_x, total_y;
  logic                 ovf_x, ovf_y;

  function automatic logic signed [RW-1:0] round_q14(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + SW'(8192)) >>> 14;
    return r[RW-1:0];
  endfunction

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  always_comb begin
    if (use_inverse) begin
      sum_x     = SW'(cpx) + SW'(spy);
      sum_y     = SW'(cpy) - SW'(spx);
      off_sum_x = -(SW'(ctx) + SW'(sty));
      off_sum_y = SW'(stx) - SW'(cty);
      off_x     = round_q14(off_sum_x);
      off_y     = round_q14(off_sum_y);
    end else begin
      sum_x     = SW'(cpx) - SW'(spy);
      sum_y     = SW'(spx) + SW'(cpy);
      off_sum_x = '0;
      off_sum_y = '0;
      off_x     = RW'(shift_x);
      off_y     = RW'(shift_y);
    end
    rnd_x = round_q14(sum_x);
    rnd_y = round_q14(sum_y);
  end

  always_comb begin
    total_x = TW'(rx2) + TW'(ox2);
    total_y = TW'(ry2) + TW'(oy2);
    ovf_x   = total_x[TW-1:COORD_WIDTH-1] != {(TW-COORD_WIDTH+1){total_x[TW-1]}};
    ovf_y   = total_y[TW-1:COORD_WIDTH-1] != {(TW-COORD_WIDTH+1){total_y[TW-1]}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      px0 <= point_x;
      py0 <= point_y;
    end
    if (rdy1 && v0) begin
      cpx <= PW'(cos_value) * PW'(px0);
      spy <= PW'(sin_value) * PW'(py0);
      spx <= PW'(sin_value) * PW'(px0);
      cpy <= PW'(cos_value) * PW'(py0);
      ctx <= PW'(cos_value) * PW'(shift_x);
      sty <= PW'(sin_value) * PW'(shift_y);
      stx <= PW'(sin_value) * PW'(shift_x);
      cty <= PW'(cos_value) * PW'(shift_y);
    end
    if (rdy2 && v1) begin
      rx2 <= rnd_x;
      ry2 <= rnd_y;
      ox2 <= off_x;
      oy2 <= off_y;
    end
    if (rdy3 && v2) begin
      moved_x <= ovf_x ? (total_x[TW-1] ? SAT_MIN : SAT_MAX) : total_x[COORD_WIDTH-1:0];
      moved_y <= ovf_y ? (total_y[TW-1] ? SAT_MIN : SAT_MAX) : total_y[COORD_WIDTH-1:0];
      clipped <= ovf_x || ovf_y;
    end
  end

endmodule

// ===== hw/rtl/rigid_transform_2d_point.sv =====
// Planar rigid transform of a point stream: one point per cycle while the CORDIC is idle
// and the output is not stalled; each point passes through four register stages.
// Writing the angle starts the iterative CORDIC; both channels hold off meanwhile.
// Reset is synchronous: config registers clear to zero, cosine to one, sine to zero.
// Depends on rt2d_pkg, rt2d_cordic and rt2d_datapath.
module rigid_transform_2d_point import rt2d_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  localparam int CFG_DATA_WIDTH = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH,
  localparam int TDATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [TDATA_WIDTH-1:0]     s_tdata,  // point_x, point_y
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [TDATA_WIDTH-1:0]     m_tdata,  // moved_x, moved_y
  output logic                       m_tuser   // clipped
);

  logic signed [COORD_WIDTH-1:0] shift_x;
  logic signed [COORD_WIDTH-1:0] shift_y;
  logic                          use_inverse;
  logic                          busy;
  logic                          cfg_write;
  logic signed [TRIG_WIDTH-1:0]  cos_value;
  logic signed [TRIG_WIDTH-1:0]  sin_value;
  logic                          dp_ready;
  logic signed [COORD_WIDTH-1:0] moved_x;
  logic signed [COORD_WIDTH-1:0] moved_y;

  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign s_tready  = dp_ready && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x     <= '0;
      shift_y     <= '0;
      use_inverse <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHIFT_X:     shift_x     <= cfg_data[COORD_WIDTH-1:0];
        REG_SHIFT_Y:     shift_y     <= cfg_data[COORD_WIDTH-1:0];
        REG_USE_INVERSE: use_inverse <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  rt2d_cordic #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_write && (cfg_index == REG_ANGLE)),
    .angle    (cfg_data[ANGLE_WIDTH-1:0]),
    .busy     (busy),
    .cos_value(cos_value),
    .sin_value(sin_value)
  );

  rt2d_datapath #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid && !busy),
    .in_ready   (dp_ready),
    .point_x    (s_tdata[COORD_WIDTH-1:0]),
    .point_y    (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .cos_value  (cos_value),
    .sin_value  (sin_value),
    .shift_x    (shift_x),
    .shift_y    (shift_y),
    .use_inverse(use_inverse),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .moved_x    (moved_x),
    .moved_y    (moved_y),
    .clipped    (m_tuser)
  );

  assign m_tdata = TDATA_WIDTH'({moved_y, moved_x});

endmodule
